// ----- rtl/tcfb_pkg.sv -----
`timescale 1ns / 1ps
package tcfb_pkg;

    // field widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SCID_W     = 10;
    localparam int unsigned VCID_W     = 6;
    localparam int unsigned LEN_W      = 10;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned DCOUNT_W   = 10;
    localparam int unsigned LIM_W      = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    // frame layout
    localparam int unsigned HDR_OCTETS = 5;
    localparam int unsigned PHASE_W    = $clog2(HDR_OCTETS + 1);
    localparam int unsigned HDR_IDX_W  = $clog2(HDR_OCTETS);

    // command queue between front and back
    localparam int unsigned CMD_QUEUE_DEPTH = 2;

    // default frame size bound
    localparam int unsigned MAX_FRAME_OCTETS_DEF = 1024;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_DATA  = 2'd0,
        OP_INC   = 2'd1,
        OP_SET   = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPACECRAFT_ID = 3'd0,
        REG_CTRL_FLAG     = 3'd1,
        REG_BYPASS_FLAG   = 3'd2,
        REG_VIRTUAL_CHAN  = 3'd3,
        REG_LENGTH_FIELD  = 3'd4,
        REG_ERR_CTRL      = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_data;
        logic [BYTE_W-1:0] new_count;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_end;
    } result_t;

    // one queued command: optional header, then one data word
    typedef struct packed {
        logic                              start;
        logic [HDR_OCTETS-1:0][BYTE_W-1:0] header;
        logic [BYTE_W-1:0]                 data_byte;
        logic                              frame_end;
    } cmd_t;

endpackage

// ----- rtl/telecommand_frame_builder_unit.sv -----
`timescale 1ns / 1ps
// Telecommand transfer frame builder.
// Input side is a queue: drive item and raise push while full is low. Each
// item is a data byte, bumps the sequence count, loads it, or does nothing.
// Result side is a queue too: while empty is low, result holds the oldest
// frame word; raise pop to take it.
// The first data byte of a frame yields six words (five header octets and
// the byte itself); later bytes yield one word until the data limit is hit.
// Items are taken one per cycle while full is low. A two-entry command queue
// parts the intake from the output sequencer, so a frame start fills it and
// full rises while the header octets drain, one per cycle while pop is high.
// An item's words pass through the command queue, then the output register.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while the block is idle.
// Reset clears the configuration, sequence count and frame state and empties
// both queues. When the receiver stalls, words wait in the output register,
// the command queue fills, and full holds off further input.
module telecommand_frame_builder_unit
    import tcfb_pkg::*;
#(
    parameter int unsigned MAX_FRAME_OCTETS = MAX_FRAME_OCTETS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  item_t                 item,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t cmd_wr, cmd_rd;

    assign cfg_ready = 1'b1;

    // intake and frame state
    tcfb_front #(
        .MAX_FRAME_OCTETS (MAX_FRAME_OCTETS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_wr),
        .cmd_full  (cmd_full)
    );

    // command queue
    tcfb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wr),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    // output sequencer
    tcfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_rd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// ----- rtl/tcfb_front.sv -----
`timescale 1ns / 1ps
module tcfb_front
    import tcfb_pkg::*;
#(
    parameter int unsigned MAX_FRAME_OCTETS = MAX_FRAME_OCTETS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  item_t                 item,
    output logic                  full,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  cmd_push,
    output cmd_t                  cmd,
    input  logic                  cmd_full
);

    localparam logic signed [LIM_W-1:0] LimMax = LIM_W'(MAX_FRAME_OCTETS - 5);
    localparam logic [DCOUNT_W-1:0]     DcMax  = '1;

    logic [SCID_W-1:0]   scid_reg;
    logic                ctrl_flag_reg;
    logic                bypass_reg;
    logic [VCID_W-1:0]   vcid_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                ecp_reg;

    logic [BYTE_W-1:0]   seq_reg, seq_next;
    logic                inside_reg, inside_next;
    logic [DCOUNT_W-1:0] dcount_reg, dcount_next;
    logic                lim_hit_reg, lim_hit_next;

    logic                  accept;
    logic                  start;
    logic [DCOUNT_W-1:0]   dc_base, dc_inc;
    logic                  lr_base;
    logic signed [LIM_W-1:0] lim_raw, lim;
    logic                  reach;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scid_reg      <= '0;
            ctrl_flag_reg <= 1'b0;
            bypass_reg    <= 1'b0;
            vcid_reg      <= '0;
            len_reg       <= '0;
            ecp_reg       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SPACECRAFT_ID: scid_reg      <= cfg_data[SCID_W-1:0];
                REG_CTRL_FLAG:     ctrl_flag_reg <= cfg_data[0];
                REG_BYPASS_FLAG:   bypass_reg    <= cfg_data[0];
                REG_VIRTUAL_CHAN:  vcid_reg      <= cfg_data[VCID_W-1:0];
                REG_LENGTH_FIELD:  len_reg       <= cfg_data[LEN_W-1:0];
                REG_ERR_CTRL:      ecp_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // data field limit, clamped to the frame size bound
    always_comb
    begin
        lim_raw = $signed({{(LIM_W-LEN_W){1'b0}}, len_reg}) - LIM_W'(4)
                  - (ecp_reg ? LIM_W'(2) : LIM_W'(0));
        lim     = (lim_raw > LimMax) ? LimMax : lim_raw;
    end

    // classify the word and update frame state
    always_comb
    begin
        start        = !inside_reg;
        dc_base      = start ? '0 : dcount_reg;
        lr_base      = start ? 1'b0 : lim_hit_reg;
        dc_inc       = (dc_base < DcMax) ? dc_base + 1'b1 : dc_base;
        reach        = (lim >= LIM_W'(1)) &&
                       ($signed({{(LIM_W-DCOUNT_W){1'b0}}, dc_inc}) >= lim);

        seq_next     = seq_reg;
        inside_next  = inside_reg;
        dcount_next  = dcount_reg;
        lim_hit_next = lim_hit_reg;
        cmd_push     = 1'b0;

        cmd.start      = start;
        cmd.header[0]  = {2'b00, bypass_reg, ctrl_flag_reg, 2'b00, scid_reg[9:8]};
        cmd.header[1]  = scid_reg[7:0];
        cmd.header[2]  = {vcid_reg, len_reg[9:8]};
        cmd.header[3]  = len_reg[7:0];
        cmd.header[4]  = seq_reg;
        cmd.data_byte  = item.data_byte;
        cmd.frame_end  = item.end_of_data || reach;

        if (accept)
        begin
            unique case (op_t'(item.operation))
                OP_INC:  seq_next = seq_reg + 1'b1;
                OP_SET:  seq_next = item.new_count;
                OP_DATA:
                begin
                    inside_next  = !item.end_of_data;
                    dcount_next  = dc_base;
                    lim_hit_next = lr_base;
                    if (!lr_base)
                    begin
                        dcount_next  = dc_inc;
                        lim_hit_next = reach;
                        cmd_push     = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= '0;
            inside_reg  <= 1'b0;
            dcount_reg  <= '0;
            lim_hit_reg <= 1'b0;
        end
        else
        begin
            seq_reg     <= seq_next;
            inside_reg  <= inside_next;
            dcount_reg  <= dcount_next;
            lim_hit_reg <= lim_hit_next;
        end
    end

endmodule

// ----- rtl/tcfb_queue.sv -----
`timescale 1ns / 1ps
module tcfb_queue
    import tcfb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    localparam int unsigned PtrW = $clog2(CMD_QUEUE_DEPTH);

    cmd_t              entry_reg [CMD_QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]     count_reg;
    logic              do_wr, do_rd;

    assign full    = (count_reg == (PtrW+1)'(CMD_QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // command storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(CMD_QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(CMD_QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/tcfb_back.sv -----
`timescale 1ns / 1ps
module tcfb_back
    import tcfb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  logic    cmd_empty,
    output logic    cmd_pop,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg, result_next;
    logic               emit_hdr;
    logic               adv;

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    // walk header octets, then the data word
    always_comb
    begin
        emit_hdr       = cmd.start && (phase_reg != PHASE_W'(HDR_OCTETS));
        adv            = !cmd_empty && (!out_valid_reg || pop);
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !pop;
        result_next    = result_reg;
        cmd_pop        = 1'b0;

        if (adv)
        begin
            out_valid_next = 1'b1;
            if (emit_hdr)
            begin
                result_next.frame_byte = cmd.header[phase_reg[HDR_IDX_W-1:0]];
                result_next.frame_end  = 1'b0;
                phase_next             = phase_reg + 1'b1;
            end
            else
            begin
                result_next.frame_byte = cmd.data_byte;
                result_next.frame_end  = cmd.frame_end;
                phase_next             = '0;
                cmd_pop                = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ----- tb/sv/telecommand_frame_builder_unit_tb.sv -----
`timescale 1ns / 1ps
module telecommand_frame_builder_unit_tb;
    import tcfb_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 3;
    localparam int MAX_IDLE        = 18;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int LONG_FRAME_LEN  = 12;
    localparam int MAX_SHORT_FRAME = 24;

    // one full set of frame registers
    typedef struct packed {
        logic [SCID_W-1:0] scid;
        logic              ctrl;
        logic              bypass;
        logic [VCID_W-1:0] vcid;
        logic [LEN_W-1:0]  len;
        logic              ecp;
    } reg_plan_t;

    // frame predictor and store of expected frame words
    class frame_scoreboard;
        logic [SCID_W-1:0]   scid;
        logic                ctrl_flag;
        logic                bypass;
        logic [VCID_W-1:0]   vcid;
        logic [LEN_W-1:0]    len_field;
        logic                ecp;
        logic [BYTE_W-1:0]   seq_count;
        logic                in_frame;
        logic [DCOUNT_W-1:0] data_cnt;
        logic                at_limit;
        result_t             expected_words[$];
        int                  errors;
        int                  words_checked;
        int                  frames_opened;

        function new();
            scid          = '0;
            ctrl_flag     = 1'b0;
            bypass        = 1'b0;
            vcid          = '0;
            len_field     = '0;
            ecp           = 1'b0;
            seq_count     = '0;
            in_frame      = 1'b0;
            data_cnt      = '0;
            at_limit      = 1'b0;
            errors        = 0;
            words_checked = 0;
            frames_opened = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_SPACECRAFT_ID: scid      = value[SCID_W-1:0];
                REG_CTRL_FLAG:     ctrl_flag = value[0];
                REG_BYPASS_FLAG:   bypass    = value[0];
                REG_VIRTUAL_CHAN:  vcid      = value[VCID_W-1:0];
                REG_LENGTH_FIELD:  len_field = value[LEN_W-1:0];
                REG_ERR_CTRL:      ecp       = value[0];
                default: ;
            endcase
        endfunction

        function void add_word(logic [BYTE_W-1:0] b, logic fin);
            result_t w;
            w.frame_byte = b;
            w.frame_end  = fin;
            expected_words = {expected_words, w};
        endfunction

        function void note_item(item_t it);
            int   lim;
            logic fin;
            case (op_t'(it.operation))
                OP_INC: seq_count = seq_count + 1'b1;
                OP_SET: seq_count = it.new_count;
                OP_DATA:
                begin
                    // header octets on the first byte of a frame
                    if (!in_frame)
                    begin
                        add_word({2'b00, bypass, ctrl_flag, 2'b00, scid[9:8]}, 1'b0);
                        add_word(scid[7:0], 1'b0);
                        add_word({vcid, len_field[9:8]}, 1'b0);
                        add_word(len_field[7:0], 1'b0);
                        add_word(seq_count, 1'b0);
                        in_frame = 1'b1;
                        data_cnt = '0;
                        at_limit = 1'b0;
                        frames_opened++;
                    end
                    // data byte, limit taken from the current registers
                    if (!at_limit)
                    begin
                        lim = int'(len_field) - 4 - 2 * int'(ecp);
                        if (lim > int'(MAX_FRAME_OCTETS_DEF) - int'(HDR_OCTETS))
                            lim = int'(MAX_FRAME_OCTETS_DEF) - int'(HDR_OCTETS);
                        fin = it.end_of_data;
                        if (data_cnt != '1)
                            data_cnt = data_cnt + 1'b1;
                        if (lim >= 1 && int'(data_cnt) >= lim)
                        begin
                            at_limit = 1'b1;
                            fin      = 1'b1;
                        end
                        add_word(it.data_byte, fin);
                    end
                    if (it.end_of_data)
                        in_frame = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual byte %02h end %b",
                         $time, got.frame_byte, got.frame_end);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got.frame_byte !== want.frame_byte)
            begin
                $display("%0t: frame_byte mismatch, expected %02h actual %02h",
                         $time, want.frame_byte, got.frame_byte);
                errors++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $display("%0t: frame_end mismatch, expected %b actual %b",
                         $time, want.frame_end, got.frame_end);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    item_t                 item      = '0;
    logic                  full;
    logic                  empty;
    logic                  pop       = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    frame_scoreboard board = new();
    item_t           stim_q[$];
    logic            calm_send = 1'b0;
    logic            calm_recv = 1'b0;
    int              items_sent = 0;
    int              settings_used = 0;

    telecommand_frame_builder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic item_t make_item(op_t op, logic [BYTE_W-1:0] b, logic eod,
                                        logic [BYTE_W-1:0] nc);
        item_t it;
        it.operation   = op;
        it.data_byte   = b;
        it.end_of_data = eod;
        it.new_count   = nc;
        return it;
    endfunction

    function automatic void add_data(logic [BYTE_W-1:0] b, logic eod);
        stim_q = {stim_q, make_item(OP_DATA, b, eod, BYTE_W'($urandom_range(0, 255)))};
    endfunction

    function automatic void add_count_op(op_t op, logic [BYTE_W-1:0] nc);
        stim_q = {stim_q, make_item(op, BYTE_W'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), nc)};
    endfunction

    // one register write, valid left high for the next one
    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, value);
    endtask

    task automatic program_regs(reg_plan_t p);
        write_reg(REG_SPACECRAFT_ID, p.scid);
        write_reg(REG_CTRL_FLAG, p.ctrl);
        write_reg(REG_BYPASS_FLAG, p.bypass);
        write_reg(REG_VIRTUAL_CHAN, p.vcid);
        write_reg(REG_LENGTH_FIELD, p.len);
        write_reg(REG_ERR_CTRL, p.ecp);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // push every queued item word, with random gaps
    task automatic drive_items();
        item_t cur;
        int    gap;
        while (stim_q.size() != 0)
        begin
            gap = calm_send ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cur = stim_q.pop_front();
            push <= 1'b1;
            item <= cur;
            do @(posedge clk); while (full);
            board.note_item(cur);
            if (op_t'(cur.operation) != OP_SPARE)
                items_sent++;
        end
        push <= 1'b0;
    endtask

    // wait until every expected word is in, then let the block go quiet
    task automatic settle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls, check each popped word
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = calm_recv ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            board.check_word(result);
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("timeout with %0d words still expected", board.pending());
        $display("Some tests failed");
        $finish;
    end

    // stimulus
    initial
    begin
        reg_plan_t plan;
        int        lim;
        int        max_len;
        int        n;
        int        counted;
        logic      eod;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: limit below one, every byte passes
        add_data(8'h00, 1'b0);
        add_data(8'hFF, 1'b1);
        stim_q = {stim_q, make_item(OP_SPARE, 8'hFF, 1'b1, 8'hFF)};
        add_count_op(OP_SET, 8'hFF);
        add_count_op(OP_INC, 8'h00);
        add_count_op(OP_INC, 8'h00);
        add_data(8'h81, 1'b1);
        add_count_op(OP_SET, 8'hFE);
        drive_items();
        settle();

        // all-ones header fields, limit of two, drops and end on a dropped byte
        plan = '{scid: 10'h3FF, ctrl: 1'b1, bypass: 1'b1, vcid: 6'h3F, len: 10'd6,
                 ecp: 1'b0};
        program_regs(plan);
        add_data(8'hA5, 1'b0);
        add_data(8'h5A, 1'b0);
        add_data(8'h3C, 1'b0);
        add_data(8'hC3, 1'b1);
        add_data(8'h11, 1'b0);
        add_count_op(OP_INC, 8'h00);
        add_data(8'h22, 1'b1);
        add_data(8'h77, 1'b0);
        drive_items();
        settle();

        // registers change inside an open frame, limit of one with error control
        plan = '{scid: 10'h000, ctrl: 1'b0, bypass: 1'b1, vcid: 6'h15, len: 10'd7,
                 ecp: 1'b1};
        program_regs(plan);
        add_data(8'h99, 1'b0);
        add_data(8'h66, 1'b1);
        add_data(8'h42, 1'b1);
        drive_items();
        settle();

        // zero length field with error control: negative limit
        plan = '{scid: 10'h2AA, ctrl: 1'b1, bypass: 1'b0, vcid: 6'h2A, len: 10'd0,
                 ecp: 1'b1};
        program_regs(plan);
        add_data(8'h01, 1'b0);
        add_data(8'h80, 1'b1);
        drive_items();
        settle();

        // random register settings, mostly well-formed frames
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0:       plan.scid = '0;
                1:       plan.scid = '1;
                default: plan.scid = SCID_W'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 3))
                0:       plan.vcid = '0;
                1:       plan.vcid = '1;
                default: plan.vcid = VCID_W'($urandom_range(0, 63));
            endcase
            case ($urandom_range(0, 7))
                0:       plan.len = LEN_W'($urandom_range(0, 6));
                1:       plan.len = '1;
                default: plan.len = LEN_W'($urandom_range(6, 24));
            endcase
            plan.ctrl   = 1'($urandom_range(0, 1));
            plan.bypass = 1'($urandom_range(0, 1));
            plan.ecp    = 1'($urandom_range(0, 1));
            program_regs(plan);

            lim     = int'(plan.len) - 4 - 2 * int'(plan.ecp);
            max_len = (lim >= 1) ? lim + 3 : 6;
            if (max_len > MAX_SHORT_FRAME)
                max_len = MAX_SHORT_FRAME;
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                // noise between frames
                if ($urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       add_count_op(OP_INC, BYTE_W'($urandom_range(0, 255)));
                        1:       add_count_op(OP_SET, BYTE_W'($urandom_range(0, 255)));
                        default: add_count_op(OP_SPARE, BYTE_W'($urandom_range(0, 255)));
                    endcase
                    counted++;
                end
                // one frame, occasionally left open
                n = $urandom_range(1, max_len);
                for (int k = 0; k < n; k++)
                begin
                    eod = (k == n - 1) && ($urandom_range(0, 7) != 0);
                    add_data(BYTE_W'($urandom_range(0, 255)), eod);
                    if (!eod && $urandom_range(0, 11) == 0)
                        add_count_op($urandom_range(0, 1) ? OP_INC : OP_SET,
                                     BYTE_W'($urandom_range(0, 255)));
                end
                counted += n;
            end
            calm_send = ($urandom_range(0, 3) == 0);
            calm_recv = ($urandom_range(0, 3) == 0);
            drive_items();
            settle();
        end

        // largest length field: one frame well inside the highest limit
        calm_send   = 1'b0;
        calm_recv   = 1'b0;
        plan.scid   = SCID_W'($urandom_range(0, 1023));
        plan.ctrl   = 1'($urandom_range(0, 1));
        plan.bypass = 1'($urandom_range(0, 1));
        plan.vcid   = VCID_W'($urandom_range(0, 63));
        plan.len    = '1;
        plan.ecp    = 1'b0;
        program_regs(plan);
        for (int k = 0; k < LONG_FRAME_LEN; k++)
            add_data(BYTE_W'($urandom_range(0, 255)), k == LONG_FRAME_LEN - 1);
        drive_items();
        settle();

        $display("ran %0d input words over %0d register settings, %0d frames opened",
                 items_sent, settings_used, board.frames_opened);
        $display("checked %0d frame words, %0d errors", board.words_checked, board.errors);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- telecommand_frame_builder_unit.f -----
rtl/tcfb_pkg.sv
rtl/tcfb_front.sv
rtl/tcfb_queue.sv
rtl/tcfb_back.sv
rtl/telecommand_frame_builder_unit.sv
tb/sv/telecommand_frame_builder_unit_tb.sv
